[hw/rtl/cluster_free_list_allocator_macros.svh]
// ---------------------------------------------------------------------------
// Cluster free list allocator assertion macros
// Shared property wrappers for the allocator's concurrent checks.
// ---------------------------------------------------------------------------
`ifndef CLUSTER_FREE_LIST_ALLOCATOR_MACROS_SVH
`define CLUSTER_FREE_LIST_ALLOCATOR_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define CFLA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define CFLA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/cfla_pkg.sv]
// ---------------------------------------------------------------------------
// Cluster free list allocator package
// Operation and status codes and the packing of the stream payloads.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cfla_pkg;

  localparam logic [1:0] OP_FORMAT  = 2'd0;
  localparam logic [1:0] OP_RESERVE = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;

  localparam int OPCODE_W = 2;
  localparam int POOL_W   = 1;
  localparam int START_W  = 12;
  localparam int COUNT_W  = 13;
  localparam int STATUS_W = 2;
  localparam int GRANT_W  = 12;
  localparam int FREE_W   = 13;

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 32;

endpackage

`default_nettype wire

[hw/rtl/cluster_free_list_allocator.sv]
// ---------------------------------------------------------------------------
// Cluster free list allocator
// Size-ordered free lists of clusters per pool, with coalescing on release.
// ---------------------------------------------------------------------------
//  Channel   Direction  Payload (tdata, lowest bit first)
//  in_*      sink       opcode[1:0] pool[2] start_index[14:3] count[27:15]
//  out_*     source     status[1:0] granted_index[13:2] free_total[26:14]
//
//  Sequence: a transaction passes through accept, decode and result, with any
//  list walks between decode and result. A reserve that splits a cluster walks
//  the list twice; a release walks it once and then links the merged cluster
//  through its finish, read (not at the head), link and set states. The walk speed
//  is set by the single read port of the link and length memories, one link per cycle.
//  Reset: rst_n is synchronous and active low. It empties every pool's list
//  and clears the free counters; the cluster memories are not cleared.
//  Stalls: a new transaction is taken only while the sequencer is idle; a
//  finished result waits in the output register while the next one is taken.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cluster_free_list_allocator #(
  parameter int STORE_ENTRIES = 4096,
  parameter int POOL_COUNT    = 2
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // opcode[1:0], pool[2], start_index[14:3], count[27:15], zeros above
  input  wire logic [31:0] in_tdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // status[1:0], granted_index[13:2], free_total[26:14], zeros above
  output logic [31:0]      out_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready
);

  // Address and length widths follow the store size; request width is max(LW, COUNT_W).
  localparam int AW = $clog2(STORE_ENTRIES);
  localparam int LW = $clog2(STORE_ENTRIES + 1);
  localparam int KW = (LW > cfla_pkg::COUNT_W) ? LW : cfla_pkg::COUNT_W;
  localparam int PW = (POOL_COUNT > 1) ? $clog2(POOL_COUNT) : 1;

  // A link is an entry index with an end flag above it.
  typedef logic [AW:0] link_t;
  localparam link_t END_LINK = {1'b1, {AW{1'b0}}};

  // Sequencer states.
  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_DECODE    = 4'd1;
  localparam logic [3:0] S_RSV       = 4'd2;
  localparam logic [3:0] S_INS_START = 4'd3;
  localparam logic [3:0] S_INS_WALK  = 4'd4;
  localparam logic [3:0] S_INS_LINK  = 4'd5;
  localparam logic [3:0] S_INS_SET   = 4'd6;
  localparam logic [3:0] S_REL       = 4'd7;
  localparam logic [3:0] S_REL_FIN   = 4'd8;
  localparam logic [3:0] S_REL_RD    = 4'd9;
  localparam logic [3:0] S_OUT       = 4'd10;

  // Any link with its end flag set or pointing past the store ends the list.
  function automatic link_t link_of(input link_t v);
    link_t r;
    r = v;
    if (v[AW] || ((AW + 1)'(v[AW-1:0]) >= (AW + 1)'(STORE_ENTRIES))) begin
      r = END_LINK;
    end
    return r;
  endfunction

  // Cluster memories: the link and the length kept at a cluster's first entry.
  link_t           link_mem [STORE_ENTRIES];
  logic [LW-1:0]   len_mem  [STORE_ENTRIES];
  link_t           link_q;
  logic [LW-1:0]   len_q;

  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  logic            lw_en;
  logic [AW-1:0]   lw_addr;
  link_t           lw_data;
  logic            nw_en;
  logic [AW-1:0]   nw_addr;
  logic [LW-1:0]   nw_data;

  // Per-pool list heads and free counters.
  link_t           head_r [POOL_COUNT];
  logic [LW-1:0]   free_r [POOL_COUNT];
  logic            hw_en;
  link_t           hw_data;
  logic            fw_en;
  logic [LW-1:0]   fw_data;

  // Sequencer registers.
  logic [3:0]      state_r, state_nxt;
  logic [1:0]      op_r;
  logic [PW-1:0]   pool_r;
  logic            pool_ok_r;
  logic            range_ok_r;
  logic [AW-1:0]   start_r, start_nxt;
  logic [KW-1:0]   cnt_r, cnt_nxt;
  logic            prev_head_r, prev_head_nxt;
  logic [AW-1:0]   prev_r, prev_nxt;
  link_t           cur_r, cur_nxt;
  logic [AW-1:0]   node_r, node_nxt;
  logic [LW-1:0]   nlen_r, nlen_nxt;
  logic            ins_vld_r, ins_vld_nxt;
  logic            ins_head_r, ins_head_nxt;
  logic [AW-1:0]   ins_r, ins_nxt;
  logic [LW-1:0]   steps_r, steps_nxt;
  logic [1:0]      status_r, status_nxt;
  logic [AW-1:0]   granted_r, granted_nxt;

  // Output register.
  logic            out_valid_r, out_valid_nxt;
  logic [1:0]      out_status_r, out_status_nxt;
  logic [AW-1:0]   out_granted_r, out_granted_nxt;
  logic [LW-1:0]   out_free_r, out_free_nxt;

  // Accepted input fields.
  logic            in_accept;
  logic [1:0]      in_opcode;
  logic            in_pool;
  logic [11:0]     in_start;
  logic [12:0]     in_count;

  // Working values.
  link_t           head_sel;
  link_t           head_lnk;
  logic [LW-1:0]   free_sel;
  link_t           lnk;
  logic [AW-1:0]   cur_idx;
  logic [LW-1:0]   steps_inc;
  logic            walk_stop;
  logic [KW:0]     free_sum;
  logic [LW-1:0]   rem;
  logic            adjacent;
  logic            fin_head;
  logic [AW-1:0]   fin_idx;

  assign in_opcode = in_tdata[1:0];
  assign in_pool   = in_tdata[2];
  assign in_start  = in_tdata[14:3];
  assign in_count  = in_tdata[27:15];
  assign in_tready = (state_r == S_IDLE);
  assign in_accept = in_tvalid && in_tready;

  assign head_sel  = head_r[pool_r];
  assign head_lnk  = link_of(head_sel);
  assign free_sel  = free_r[pool_r];
  assign lnk       = link_of(link_q);
  assign cur_idx   = cur_r[AW-1:0];
  assign steps_inc = steps_r + 1'b1;
  // The walk also ends after one full store's worth of links, so a damaged
  // list can never hold the sequencer forever.
  assign walk_stop = lnk[AW] || (steps_inc == LW'(STORE_ENTRIES));
  assign free_sum  = (KW + 1)'(free_sel) + (KW + 1)'(cnt_r);
  assign rem       = len_q - LW'(cnt_r);
  assign adjacent  = (((KW + 1)'(cur_idx) + (KW + 1)'(len_q)) == (KW + 1)'(start_r)) ||
                     (((KW + 1)'(start_r) + (KW + 1)'(cnt_r)) == (KW + 1)'(cur_idx));
  assign fin_head  = ins_vld_r ? ins_head_r : prev_head_r;
  assign fin_idx   = ins_vld_r ? ins_r : prev_r;

  always_comb begin
    state_nxt       = state_r;
    start_nxt       = start_r;
    cnt_nxt         = cnt_r;
    prev_head_nxt   = prev_head_r;
    prev_nxt        = prev_r;
    cur_nxt         = cur_r;
    node_nxt        = node_r;
    nlen_nxt        = nlen_r;
    ins_vld_nxt     = ins_vld_r;
    ins_head_nxt    = ins_head_r;
    ins_nxt         = ins_r;
    steps_nxt       = steps_r;
    status_nxt      = status_r;
    granted_nxt     = granted_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_status_nxt  = out_status_r;
    out_granted_nxt = out_granted_r;
    out_free_nxt    = out_free_r;
    rd_en           = 1'b0;
    rd_addr         = cur_idx;
    lw_en           = 1'b0;
    lw_addr         = prev_r;
    lw_data         = lnk;
    nw_en           = 1'b0;
    nw_addr         = start_r;
    nw_data         = LW'(cnt_r);
    hw_en           = 1'b0;
    hw_data         = lnk;
    fw_en           = 1'b0;
    fw_data         = free_sel;

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          start_nxt   = AW'(in_start);
          cnt_nxt     = KW'(in_count);
          status_nxt  = cfla_pkg::ST_DONE;
          granted_nxt = '0;
          state_nxt   = S_DECODE;
        end
      end

      S_DECODE: begin
        state_nxt     = S_OUT;
        prev_head_nxt = 1'b1;
        ins_vld_nxt   = 1'b0;
        steps_nxt     = '0;
        cur_nxt       = head_lnk;
        rd_addr       = head_lnk[AW-1:0];
        if (!pool_ok_r) begin
          status_nxt = cfla_pkg::ST_RANGE;
        end else begin
          case (op_r)
            cfla_pkg::OP_FORMAT: begin
              if (!range_ok_r) begin
                status_nxt = cfla_pkg::ST_RANGE;
              end else begin
                lw_en   = 1'b1;
                lw_addr = start_r;
                lw_data = END_LINK;
                nw_en   = 1'b1;
                hw_en   = 1'b1;
                hw_data = {1'b0, start_r};
                fw_en   = 1'b1;
                fw_data = LW'(cnt_r);
              end
            end
            cfla_pkg::OP_RESERVE: begin
              if (cnt_r == '0) begin
                status_nxt = cfla_pkg::ST_RANGE;
              end else if (head_lnk[AW]) begin
                status_nxt = cfla_pkg::ST_NOSPACE;
              end else begin
                rd_en     = 1'b1;
                state_nxt = S_RSV;
              end
            end
            cfla_pkg::OP_RELEASE: begin
              if (!range_ok_r) begin
                status_nxt = cfla_pkg::ST_RANGE;
              end else begin
                fw_en   = 1'b1;
                fw_data = (free_sum > (KW + 1)'(STORE_ENTRIES)) ?
                          LW'(STORE_ENTRIES) : LW'(free_sum);
                if (head_lnk[AW]) begin
                  state_nxt = S_REL_FIN;
                end else begin
                  rd_en     = 1'b1;
                  state_nxt = S_REL;
                end
              end
            end
            default: begin
              state_nxt = S_OUT;
            end
          endcase
        end
      end

      S_RSV: begin
        if (KW'(len_q) >= cnt_r) begin
          // First fit: unlink the cluster, then hand out its tail.
          if (prev_head_r) begin
            hw_en = 1'b1;
          end else begin
            lw_en = 1'b1;
          end
          fw_en   = 1'b1;
          fw_data = (KW'(free_sel) > cnt_r) ? LW'(KW'(free_sel) - cnt_r) : '0;
          if (KW'(len_q) == cnt_r) begin
            granted_nxt = cur_idx;
            state_nxt   = S_OUT;
          end else begin
            granted_nxt = cur_idx + AW'(rem);
            nw_en       = 1'b1;
            nw_addr     = cur_idx;
            nw_data     = rem;
            node_nxt    = cur_idx;
            nlen_nxt    = rem;
            state_nxt   = S_INS_START;
          end
        end else begin
          prev_head_nxt = 1'b0;
          prev_nxt      = cur_idx;
          cur_nxt       = lnk;
          steps_nxt     = steps_inc;
          if (walk_stop) begin
            status_nxt = cfla_pkg::ST_NOSPACE;
            state_nxt  = S_OUT;
          end else begin
            rd_en   = 1'b1;
            rd_addr = lnk[AW-1:0];
          end
        end
      end

      S_INS_START: begin
        // Walk again from the head to find the remainder's sorted place.
        prev_head_nxt = 1'b1;
        steps_nxt     = '0;
        cur_nxt       = head_lnk;
        if (head_lnk[AW]) begin
          state_nxt = S_INS_LINK;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = head_lnk[AW-1:0];
          state_nxt = S_INS_WALK;
        end
      end

      S_INS_WALK: begin
        if (nlen_r <= len_q) begin
          state_nxt = S_INS_LINK;
        end else begin
          prev_head_nxt = 1'b0;
          prev_nxt      = cur_idx;
          cur_nxt       = lnk;
          steps_nxt     = steps_inc;
          if (walk_stop) begin
            state_nxt = S_INS_LINK;
          end else begin
            rd_en   = 1'b1;
            rd_addr = lnk[AW-1:0];
          end
        end
      end

      S_INS_LINK: begin
        lw_en     = 1'b1;
        lw_addr   = node_r;
        lw_data   = cur_r;
        state_nxt = S_INS_SET;
      end

      S_INS_SET: begin
        if (prev_head_r) begin
          hw_en   = 1'b1;
          hw_data = {1'b0, node_r};
        end else begin
          lw_en   = 1'b1;
          lw_data = {1'b0, node_r};
        end
        state_nxt = S_OUT;
      end

      S_REL: begin
        steps_nxt = steps_inc;
        cur_nxt   = lnk;
        if (adjacent) begin
          // Merge the neighbor into the released range and unlink it.
          cnt_nxt     = cnt_r + KW'(len_q);
          start_nxt   = (cur_idx < start_r) ? cur_idx : start_r;
          ins_vld_nxt = 1'b0;
          if (prev_head_r) begin
            hw_en = 1'b1;
          end else begin
            lw_en = 1'b1;
          end
        end else begin
          if (!ins_vld_r && (cnt_r <= KW'(len_q))) begin
            ins_vld_nxt  = 1'b1;
            ins_head_nxt = prev_head_r;
            ins_nxt      = prev_r;
          end
          prev_head_nxt = 1'b0;
          prev_nxt      = cur_idx;
        end
        if (walk_stop) begin
          state_nxt = S_REL_FIN;
        end else begin
          rd_en   = 1'b1;
          rd_addr = lnk[AW-1:0];
        end
      end

      S_REL_FIN: begin
        nw_en         = 1'b1;
        node_nxt      = start_r;
        prev_head_nxt = fin_head;
        prev_nxt      = fin_idx;
        if (fin_head) begin
          cur_nxt   = head_lnk;
          state_nxt = S_INS_LINK;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = fin_idx;
          state_nxt = S_REL_RD;
        end
      end

      S_REL_RD: begin
        cur_nxt   = lnk;
        state_nxt = S_INS_LINK;
      end

      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = status_r;
          out_granted_nxt = (status_r == cfla_pkg::ST_DONE &&
                             op_r == cfla_pkg::OP_RESERVE) ? granted_r : '0;
          out_free_nxt    = pool_ok_r ? free_sel : '0;
          state_nxt       = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Synchronous memories with a registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      link_q <= link_mem[rd_addr];
      len_q  <= len_mem[rd_addr];
    end
    if (lw_en) begin
      link_mem[lw_addr] <= lw_data;
    end
    if (nw_en) begin
      len_mem[nw_addr] <= nw_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < POOL_COUNT; i++) begin
        head_r[i] <= END_LINK;
        free_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (hw_en) begin
        head_r[pool_r] <= hw_data;
      end
      if (fw_en) begin
        free_r[pool_r] <= fw_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_r       <= in_opcode;
      pool_r     <= PW'(in_pool);
      pool_ok_r  <= (32'(in_pool) < POOL_COUNT);
      range_ok_r <= (in_count != '0) &&
                    ((32'(in_start) + 32'(in_count)) <= 32'(STORE_ENTRIES));
    end
    start_r       <= start_nxt;
    cnt_r         <= cnt_nxt;
    prev_head_r   <= prev_head_nxt;
    prev_r        <= prev_nxt;
    cur_r         <= cur_nxt;
    node_r        <= node_nxt;
    nlen_r        <= nlen_nxt;
    ins_vld_r     <= ins_vld_nxt;
    ins_head_r    <= ins_head_nxt;
    ins_r         <= ins_nxt;
    steps_r       <= steps_nxt;
    status_r      <= status_nxt;
    granted_r     <= granted_nxt;
    out_status_r  <= out_status_nxt;
    out_granted_r <= out_granted_nxt;
    out_free_r    <= out_free_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, cfla_pkg::FREE_W'(out_free_r),
                       cfla_pkg::GRANT_W'(out_granted_r), out_status_r};

`include "cluster_free_list_allocator_macros.svh"

  `CFLA_ASSERT_NEXT(a_busy_after_accept, in_accept, !in_tready, "allocator took a second transaction")
  `CFLA_ASSERT_NOW(a_result_from_out, $rose(out_tvalid), $past(state_r) == S_OUT, "result appeared outside the result state")
  `CFLA_ASSERT_NOW(a_grant_only_done, out_tvalid && (out_tdata[1:0] != cfla_pkg::ST_DONE), out_tdata[13:2] == '0, "grant index set on a failed transaction")
  `CFLA_ASSERT_NOW(a_walk_bounded, (state_r == S_RSV) || (state_r == S_REL) || (state_r == S_INS_WALK), steps_r < LW'(STORE_ENTRIES), "list walk ran past the store size")

endmodule

`default_nettype wire

[test/cluster_free_list_allocator_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Cluster free list allocator checker
// Watches both stream channels, predicts every result from its own model of
// the pools and compares each result transaction field by field in order.
// ---------------------------------------------------------------------------
module cluster_free_list_allocator_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [31:0] in_tdata,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [31:0] out_tdata,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  output int               errors,
  output int               pending,
  output logic             grant_ok,
  output logic [11:0]      grant_index
);

  localparam int ENTRIES = 4096;
  localparam int unsigned NIL = 32'hFFFF_FFFF;
  localparam int unsigned HEAD_NODE = 32'hFFFF_FFFE;

  typedef struct packed {
    logic [cfla_pkg::STATUS_W-1:0] status;
    logic [cfla_pkg::GRANT_W-1:0]  granted;
    logic [cfla_pkg::FREE_W-1:0]   free_total;
  } alloc_result_t;

  alloc_result_t result_q[$];

  int unsigned nlink[ENTRIES];
  bit          single[ENTRIES];
  int unsigned clen[ENTRIES];
  int unsigned head[2];
  int unsigned free_cnt[2];

  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      nlink[i] = 0;
      single[i] = 0;
      clen[i] = 0;
    end
    head[0] = NIL;
    head[1] = NIL;
    free_cnt[0] = 0;
    free_cnt[1] = 0;
    errors = 0;
    pending = 0;
    grant_ok = 1'b0;
    grant_index = '0;
  end

  function automatic int unsigned next_of(int unsigned p, int unsigned node);
    int unsigned v;
    v = (node == HEAD_NODE) ? head[p] : nlink[node];
    return (v < ENTRIES) ? v : NIL;
  endfunction

  function automatic void link_to(int unsigned p, int unsigned node, int unsigned v);
    if (node == HEAD_NODE) head[p] = v;
    else nlink[node] = v;
  endfunction

  function automatic int unsigned cluster_size(int unsigned node);
    return single[node] ? 1 : clen[node];
  endfunction

  function automatic void set_size(int unsigned node, int unsigned len);
    single[node] = (len == 1);
    clen[node] = len;
  endfunction

  // Link a cluster in front of the first one that is at least as large.
  function automatic void place_sorted(int unsigned p, int unsigned node, int unsigned len);
    int unsigned prev, cur, steps;
    prev = HEAD_NODE;
    steps = 0;
    cur = next_of(p, prev);
    while (cur != NIL && steps < ENTRIES) begin
      if (len <= cluster_size(cur)) break;
      prev = cur;
      steps++;
      cur = next_of(p, prev);
    end
    link_to(p, node, next_of(p, prev));
    link_to(p, prev, node);
  endfunction

  function automatic alloc_result_t pool_step(logic [31:0] d);
    alloc_result_t r;
    logic [1:0] op;
    int unsigned p, start, cnt, status, granted;
    int unsigned prev, cur, steps, size, ins, f, rem;
    bit in_range, found;
    op = d[1:0];
    p = d[2];
    start = d[14:3];
    cnt = d[27:15];
    status = cfla_pkg::ST_DONE;
    granted = 0;
    in_range = (cnt != 0) && (start + cnt <= ENTRIES);
    if (op == cfla_pkg::OP_FORMAT) begin
      if (!in_range) status = cfla_pkg::ST_RANGE;
      else begin
        nlink[start] = NIL;
        set_size(start, cnt);
        head[p] = start;
        free_cnt[p] = cnt;
      end
    end else if (op == cfla_pkg::OP_RESERVE) begin
      if (cnt == 0) status = cfla_pkg::ST_RANGE;
      else begin
        prev = HEAD_NODE;
        steps = 0;
        size = 0;
        found = 0;
        cur = next_of(p, prev);
        while (cur != NIL && steps < ENTRIES) begin
          size = cluster_size(cur);
          if (cnt <= size) begin
            found = 1;
            break;
          end
          prev = cur;
          steps++;
          cur = next_of(p, prev);
        end
        if (!found) status = cfla_pkg::ST_NOSPACE;
        else begin
          link_to(p, prev, next_of(p, cur));
          if (size == cnt) granted = cur;
          else begin
            // The tail goes out; the head stays free and is re-sorted.
            rem = size - cnt;
            granted = cur + rem;
            set_size(cur, rem);
            place_sorted(p, cur, rem);
          end
          free_cnt[p] = (free_cnt[p] > cnt) ? free_cnt[p] - cnt : 0;
        end
      end
    end else if (op == cfla_pkg::OP_RELEASE) begin
      if (!in_range) status = cfla_pkg::ST_RANGE;
      else begin
        prev = HEAD_NODE;
        ins = NIL;
        steps = 0;
        f = free_cnt[p] + cnt;
        free_cnt[p] = (f > ENTRIES) ? ENTRIES : f;
        // One pass: neighbors are merged as they are met, and the chosen
        // insertion point is forgotten after every merge.
        cur = next_of(p, prev);
        while (cur != NIL && steps < ENTRIES) begin
          size = cluster_size(cur);
          steps++;
          if (cur + size == start || start + cnt == cur) begin
            cnt += size;
            if (cur < start) start = cur;
            link_to(p, prev, next_of(p, cur));
            ins = NIL;
          end else begin
            if (ins == NIL && cnt <= size) ins = prev;
            prev = cur;
          end
          cur = next_of(p, prev);
        end
        set_size(start, cnt);
        if (ins == NIL) ins = prev;
        link_to(p, start, next_of(p, ins));
        link_to(p, ins, start);
      end
    end
    r.status = status;
    r.granted = (status == cfla_pkg::ST_DONE && op == cfla_pkg::OP_RESERVE) ?
                granted[11:0] : '0;
    r.free_total = free_cnt[p][12:0];
    return r;
  endfunction

  task automatic report(string field, int unsigned exp_v, int unsigned got_v);
    $display("mismatch %s: expected %0d, got %0d", field, exp_v, got_v);
    errors++;
  endtask

  always @(posedge clk) begin
    alloc_result_t exp_r;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        exp_r = pool_step(in_tdata);
        result_q.push_back(exp_r);
        grant_ok <= (in_tdata[1:0] == cfla_pkg::OP_RESERVE) &&
                    (exp_r.status == cfla_pkg::ST_DONE);
        grant_index <= exp_r.granted;
      end
      if (out_tvalid && out_tready) begin
        if (result_q.size() == 0) begin
          report("results waiting", 0, 1);
        end else begin
          exp_r = result_q.pop_front();
          if (out_tdata[1:0] != exp_r.status)
            report("status", exp_r.status, out_tdata[1:0]);
          if (out_tdata[13:2] != exp_r.granted)
            report("granted_index", exp_r.granted, out_tdata[13:2]);
          if (out_tdata[26:14] != exp_r.free_total)
            report("free_total", exp_r.free_total, out_tdata[26:14]);
        end
      end
      pending <= result_q.size();
    end
  end

endmodule

[test/tb_cluster_free_list_allocator.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Cluster free list allocator testbench
// Directed and random pool traffic with random idling on both channels; a
// checker beside the block predicts and compares every result transaction.
// ---------------------------------------------------------------------------
module tb_cluster_free_list_allocator;

  // Opcode value that the block must answer without changing anything.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int N_RANDOM = 1700;
  localparam int IDLE_LIMIT = 50000;

  typedef struct {
    int unsigned pool;
    int unsigned start;
    int unsigned len;
  } held_run_t;

  logic        clk;
  logic        rst_n;
  logic [31:0] in_tdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] out_tdata;
  logic        out_tvalid;
  logic        out_tready;
  int          errors;
  int          pending;
  logic        grant_ok;
  logic [11:0] grant_index;

  // Stimulus control shared between the sender and the receiver, and the watchdog's idle count.
  bit quiet;
  bit hold_req;
  int idle_cycles;

  held_run_t   held_q[$];
  int unsigned base[2];
  int unsigned span[2];

  cluster_free_list_allocator i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

  cluster_free_list_allocator_checker i_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .errors      (errors),
    .pending     (pending),
    .grant_ok    (grant_ok),
    .grant_index (grant_index)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // The watchdog ends a run in which neither channel moves a transaction
  // for far longer than the slowest list walk plus the long receiver hold.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Receiver: for every result it waits a random number of cycles before it
  // raises tready. Once it holds off for a long stretch so that the result
  // register fills and the block stops taking input transactions.
  initial begin
    int wait_cycles;
    out_tready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        wait_cycles = 400;
        hold_req = 1'b0;
      end else begin
        wait_cycles = quiet ? 0 : $urandom_range(0, 14);
      end
      if (wait_cycles > 0) begin
        out_tready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  // Offer one input transaction after a gap and return at the edge where it
  // is accepted; tvalid stays high if the next call has no gap.
  task automatic send(logic [1:0] op, int unsigned pool, int unsigned start,
                      int unsigned cnt);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= {4'b0, cnt[12:0], start[11:0], pool[0], op};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!(in_tvalid && in_tready));
  endtask

  // A reserve waits for its predicted grant so that the run can later be
  // handed back. The channel is closed meanwhile.
  task automatic reserve(int unsigned pool, int unsigned cnt);
    held_run_t run;
    send(cfla_pkg::OP_RESERVE, pool, $urandom_range(0, 4095), cnt);
    in_tvalid <= 1'b0;
    #1;
    if (grant_ok) begin
      run.pool = pool;
      run.start = grant_index;
      run.len = cnt;
      held_q.push_back(run);
    end
    @(posedge clk);
  endtask

  // Formatting a pool forgets every run that was reserved from it.
  task automatic format_pool(int unsigned pool, int unsigned cnt);
    held_run_t kept[$];
    foreach (held_q[i]) if (held_q[i].pool != pool) kept.push_back(held_q[i]);
    held_q = kept;
    send(cfla_pkg::OP_FORMAT, pool, base[pool], cnt);
  endtask

  // Hand back a whole held run or just its front part.
  task automatic release_held(int unsigned idx);
    held_run_t run;
    int unsigned part;
    run = held_q[idx];
    part = run.len;
    if (run.len > 1 && $urandom_range(0, 2) == 0) part = $urandom_range(1, run.len - 1);
    if (part == run.len) held_q.delete(idx);
    else begin
      held_q[idx].start = run.start + part;
      held_q[idx].len = run.len - part;
    end
    send(cfla_pkg::OP_RELEASE, run.pool, run.start, part);
  endtask

  // A new split of the store between the two pools; both are formatted.
  task automatic repartition();
    int unsigned split;
    split = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4095) : $urandom_range(1024, 3072);
    base[0] = 0;
    span[0] = split;
    base[1] = split;
    span[1] = 4096 - split;
    held_q.delete();
    format_pool(0, span[0]);
    format_pool(1, span[1]);
  endtask

  // Items the block must reject or leave without effect.
  task automatic send_noise();
    int unsigned s, c;
    s = $urandom_range(0, 4095);
    case ($urandom_range(0, 3))
      0: send(OP_UNUSED, $urandom_range(0, 1), s, $urandom_range(0, 8191));
      1: send(cfla_pkg::OP_FORMAT, $urandom_range(0, 1), s, 4096 - s + $urandom_range(1, 200));
      2: send(cfla_pkg::OP_RELEASE, $urandom_range(0, 1), s, 0);
      default: begin
        c = $urandom_range(4097, 8191);
        send($urandom_range(0, 1) ? cfla_pkg::OP_RELEASE : cfla_pkg::OP_FORMAT,
             $urandom_range(0, 1), s, c);
      end
    endcase
  endtask

  initial begin
    int r;
    int unsigned p, cnt;
    bit has_held;
    quiet = 1'b0;
    hold_req = 1'b0;
    in_tdata = '0;
    in_tvalid = 1'b0;
    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Pool 0 owns the whole store before pool 1 is formatted.
    send(cfla_pkg::OP_RESERVE, 0, 0, 1);           // empty list: no space
    send(cfla_pkg::OP_RELEASE, 1, 4095, 0);        // zero count: range error
    base[0] = 0;
    format_pool(0, 4096);
    send(cfla_pkg::OP_RESERVE, 0, 4095, 4096);     // exact fit of the whole store
    send(cfla_pkg::OP_RELEASE, 0, 0, 4096);
    send(cfla_pkg::OP_RESERVE, 0, 0, 1);           // single entry from the tail
    send(cfla_pkg::OP_RESERVE, 0, 0, 8191);        // larger than any cluster
    send(cfla_pkg::OP_RESERVE, 0, 0, 0);           // zero-size reserve
    send(cfla_pkg::OP_FORMAT, 0, 4095, 2);         // runs past the end of the store
    send(cfla_pkg::OP_RELEASE, 0, 4095, 1);        // merges with the cluster below it
    send(OP_UNUSED, 1, 4095, 8191);
    send(cfla_pkg::OP_RESERVE, 0, 0, 10);          // entries 4086..4095
    send(cfla_pkg::OP_RESERVE, 0, 0, 10);          // entries 4076..4085
    send(cfla_pkg::OP_RESERVE, 0, 0, 10);          // entries 4066..4075
    send(cfla_pkg::OP_RELEASE, 0, 4076, 10);       // no free neighbor
    send(cfla_pkg::OP_RELEASE, 0, 4086, 10);       // merges with the cluster below
    send(cfla_pkg::OP_RELEASE, 0, 4066, 10);       // merges on both sides
    send(cfla_pkg::OP_RELEASE, 0, 4096 - 1, 2);    // past the end of the store
    held_q.delete();

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 300 == 0) repartition();
      quiet = (n >= 800 && n < 950);
      if (n == 500) hold_req = 1'b1;
      if (n == 1100) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      r = $urandom_range(0, 99);
      p = $urandom_range(0, 1);
      has_held = 1'b0;
      foreach (held_q[i]) if (held_q[i].pool == p) has_held = 1'b1;
      if (r < 4) begin
        format_pool(p, $urandom_range(0, 1) ? span[p] : $urandom_range(1, span[p]));
      end else if (r < 50) begin
        case ($urandom_range(0, 9))
          0: cnt = $urandom_range(1, 8191);
          1: cnt = $urandom_range(1, 4096);
          default: cnt = $urandom_range(1, 32);
        endcase
        reserve(p, cnt);
      end else if (r < 88 && held_q.size() > 0) begin
        release_held($urandom_range(0, held_q.size() - 1));
      end else begin
        send_noise();
      end
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/cfla_pkg.sv
hw/rtl/cluster_free_list_allocator.sv
test/cluster_free_list_allocator_checker.sv
test/tb_cluster_free_list_allocator.sv
